// ===== rtl/dspa_pkg.sv =====
package dspa_pkg;

    // Operation codes carried by the mode field.
    localparam logic [1:0] MODE_RESERVE = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TEST    = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOTOCC = 2'd2;

    // Microprogram addresses.
    typedef logic [3:0] t_step;
    localparam t_step S_IDLE = 4'd0;
    localparam t_step S_INIT = 4'd1;
    localparam t_step S_RSV  = 4'd2;
    localparam t_step S_RSV2 = 4'd3;
    localparam t_step S_CHK  = 4'd4;
    localparam t_step S_CHK2 = 4'd5;
    localparam t_step S_CHK3 = 4'd6;
    localparam t_step S_TST  = 4'd7;
    localparam t_step S_REL1 = 4'd8;
    localparam t_step S_REL2 = 4'd9;
    localparam t_step S_CLR  = 4'd10;

    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_INIT_END = 3'd1,
        C_FULL     = 3'd2,
        C_SLOT_OOR = 3'd3,
        C_HOLE_OOR = 3'd4,
        C_MISMATCH = 3'd5,
        C_IS_TEST  = 3'd6
    } t_cond;

    typedef enum logic [2:0] {
        SAP_NONE    = 3'd0,
        SAP_RD_CNT  = 3'd1,
        SAP_RD_HOLE = 3'd2,
        SAP_RD_LAST = 3'd3,
        SAP_WR_HOLE = 3'd4,
        SAP_WR_LAST = 3'd5,
        SAP_WR_INIT = 3'd6
    } t_sap_op;

    typedef enum logic [2:0] {
        POS_NONE        = 3'd0,
        POS_RD_SLOT     = 3'd1,
        POS_WR_LASTSLOT = 3'd2,
        POS_WR_SLOT     = 3'd3,
        POS_WR_INIT     = 3'd4
    } t_pos_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_ZERO = 2'd3
    } t_cnt_op;

    // One control word. When the condition holds the sequencer jumps to idle;
    // a failing condition also suppresses every side effect of the step.
    typedef struct packed {
        t_step      nxt;
        t_cond      cond;
        logic       cond_fail;
        logic       jump_emits;
        logic [1:0] fail_status;
        logic       done;
        t_sap_op    sap_op;
        t_pos_op    pos_op;
        t_cnt_op    cnt_op;
        logic       ld_hole;
        logic       ld_given;
        logic       init_inc;
    } t_ctl;

    function automatic t_ctl ctl_rom(input t_step step);
        t_ctl c;
        c = '0;
        c.nxt         = S_IDLE;
        c.cond        = C_NONE;
        c.fail_status = ST_OK;
        c.sap_op      = SAP_NONE;
        c.pos_op      = POS_NONE;
        c.cnt_op      = CNT_HOLD;
        case (step)
            S_INIT: begin
                c.nxt      = S_INIT;
                c.cond     = C_INIT_END;
                c.sap_op   = SAP_WR_INIT;
                c.pos_op   = POS_WR_INIT;
                c.init_inc = 1'b1;
            end
            S_RSV: begin
                c.nxt         = S_RSV2;
                c.cond        = C_FULL;
                c.cond_fail   = 1'b1;
                c.jump_emits  = 1'b1;
                c.fail_status = ST_FULL;
                c.sap_op      = SAP_RD_CNT;
            end
            S_RSV2: begin
                c.done     = 1'b1;
                c.ld_given = 1'b1;
                c.cnt_op   = CNT_INC;
            end
            S_CHK: begin
                c.nxt         = S_CHK2;
                c.cond        = C_SLOT_OOR;
                c.cond_fail   = 1'b1;
                c.jump_emits  = 1'b1;
                c.fail_status = ST_NOTOCC;
                c.pos_op      = POS_RD_SLOT;
            end
            S_CHK2: begin
                c.nxt         = S_CHK3;
                c.cond        = C_HOLE_OOR;
                c.cond_fail   = 1'b1;
                c.jump_emits  = 1'b1;
                c.fail_status = ST_NOTOCC;
                c.sap_op      = SAP_RD_HOLE;
                c.ld_hole     = 1'b1;
            end
            S_CHK3: begin
                c.nxt         = S_TST;
                c.cond        = C_MISMATCH;
                c.cond_fail   = 1'b1;
                c.jump_emits  = 1'b1;
                c.fail_status = ST_NOTOCC;
            end
            S_TST: begin
                c.nxt        = S_REL1;
                c.cond       = C_IS_TEST;
                c.jump_emits = 1'b1;
                c.sap_op     = SAP_RD_LAST;
            end
            S_REL1: begin
                c.nxt    = S_REL2;
                c.sap_op = SAP_WR_HOLE;
                c.pos_op = POS_WR_LASTSLOT;
            end
            S_REL2: begin
                c.done   = 1'b1;
                c.sap_op = SAP_WR_LAST;
                c.pos_op = POS_WR_SLOT;
                c.cnt_op = CNT_DEC;
            end
            S_CLR: begin
                c.done   = 1'b1;
                c.cnt_op = CNT_ZERO;
            end
            default: begin
                c.nxt = S_IDLE;
            end
        endcase
        return c;
    endfunction

    function automatic t_step entry_step(input logic [1:0] mode);
        t_step s;
        s = S_CLR;
        case (mode)
            MODE_RESERVE: s = S_RSV;
            MODE_RELEASE: s = S_CHK;
            MODE_TEST:    s = S_CHK;
            MODE_CLEAR:   s = S_CLR;
            default:      s = S_CLR;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/dense_slot_pool_allocator_core.sv =====
// Fixed-capacity slot pool with swap-remove release. The pool keeps a dense
// list of slot numbers and, per slot, its back-index into that list; the first
// "occupied" list entries are the slots in use. A reserve hands out the list
// entry at the occupied count, a release moves the last occupied entry into
// the freed position, a test reports whether a slot is in use, and a clear
// zeroes the count while keeping the list order. Every input beat produces
// exactly one result beat. The block runs one item at a time under a small
// microprogram and takes a new beat only once back at idle; how long an item
// takes is set by the sequence of accesses to the two single-port list
// memories; a reserve ends early when full, and a test or release when the
// slot turns out not to be occupied. While a result is stalled at the
// output, the next step that produces a result is held. After reset a
// clearing pass loads entry i of both memories with i for every i below
// SLOTS; input beats are stalled during that pass, while capacity writes
// are taken at any time. Capacity values above SLOTS behave as SLOTS, and a
// capacity of zero makes every reserve report full.
module dense_slot_pool_allocator_core
    import dspa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [5:0] i_slot,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [5:0] o_given_slot,
    output logic [5:0] o_position,
    output logic [6:0] o_occupied
);

    // Position and slot numbers need PW bits, the occupied count CW bits.
    // EW is wide enough for every compare against the 6- and 7-bit ports.
    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    // Architectural state and datapath registers.
    logic [6:0]    r_cap;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    t_step         r_step;
    t_step         n_step;
    logic [PW-1:0] r_init_idx;
    logic [1:0]    r_mode;
    logic [5:0]    r_slot;
    logic [PW-1:0] r_hole;
    logic [PW-1:0] r_sap_q;
    logic [PW-1:0] r_pos_q;

    // Output register.
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [PW-1:0] r_given;
    logic [PW-1:0] r_position;
    logic [CW-1:0] r_occupied;

    // The two list memories.
    logic [PW-1:0] sap_mem [SLOTS];
    logic [PW-1:0] pos_mem [SLOTS];

    t_ctl          ctl;
    logic          cond_true;
    logic          emit;
    logic          advance;
    logic          run;
    logic          effects;
    logic          in_accept;

    logic [EW-1:0] slot_ext;
    logic [EW-1:0] cap_ext;
    logic [EW-1:0] slots_ext;
    logic [EW-1:0] cap_use;
    logic [CW-1:0] cnt_m1;
    logic [PW-1:0] slot_addr;

    logic          sap_re;
    logic          sap_we;
    logic [PW-1:0] sap_addr;
    logic [PW-1:0] sap_wd;
    logic          pos_re;
    logic          pos_we;
    logic [PW-1:0] pos_addr;
    logic [PW-1:0] pos_wd;

    logic [EW-1:0] given_ext;
    logic [EW-1:0] position_ext;
    logic [EW-1:0] occupied_ext;

    // The control word for the current step comes from the microprogram.
    assign ctl = ctl_rom(r_step);

    assign slot_ext  = EW'(r_slot);
    assign slot_addr = slot_ext[PW-1:0];
    assign cap_ext   = EW'(r_cap);
    assign slots_ext = EW'(SLOTS);
    assign cap_use   = (cap_ext > slots_ext) ? slots_ext : cap_ext;
    assign cnt_m1    = r_cnt - CW'(1);

    // Jump conditions. Each one looks at a register or at the data that the
    // previous step read from a memory.
    always_comb begin
        case (ctl.cond)
            C_NONE:     cond_true = 1'b0;
            C_INIT_END: cond_true = (r_init_idx == PW'(SLOTS - 1));
            C_FULL:     cond_true = (EW'(r_cnt) >= cap_use);
            C_SLOT_OOR: cond_true = (slot_ext >= slots_ext);
            C_HOLE_OOR: cond_true = (CW'(r_pos_q) >= r_cnt);
            C_MISMATCH: cond_true = (EW'(r_sap_q) != slot_ext);
            C_IS_TEST:  cond_true = (r_mode == MODE_TEST);
            default:    cond_true = 1'b0;
        endcase
    end

    // A step that produces a result waits while the previous result is still
    // held at the output; the whole step is frozen, side effects included.
    assign emit       = (r_step != S_IDLE) && (ctl.done || (cond_true && ctl.jump_emits));
    assign advance    = !(emit && r_out_valid && i_out_stall);
    assign run        = (r_step != S_IDLE) && advance;
    assign effects    = run && !(cond_true && ctl.cond_fail);
    assign o_in_stall = (r_step != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Dense list port.
    always_comb begin
        sap_re   = 1'b0;
        sap_we   = 1'b0;
        sap_addr = r_init_idx;
        sap_wd   = r_init_idx;
        case (ctl.sap_op)
            SAP_NONE: begin
                sap_re = 1'b0;
            end
            SAP_RD_CNT: begin
                sap_re   = effects;
                sap_addr = r_cnt[PW-1:0];
            end
            SAP_RD_HOLE: begin
                sap_re   = effects;
                sap_addr = r_pos_q;
            end
            SAP_RD_LAST: begin
                sap_re   = effects;
                sap_addr = cnt_m1[PW-1:0];
            end
            SAP_WR_HOLE: begin
                sap_we   = effects;
                sap_addr = r_hole;
                sap_wd   = r_sap_q;
            end
            SAP_WR_LAST: begin
                sap_we   = effects;
                sap_addr = cnt_m1[PW-1:0];
                sap_wd   = slot_addr;
            end
            SAP_WR_INIT: begin
                sap_we   = effects;
                sap_addr = r_init_idx;
                sap_wd   = r_init_idx;
            end
            default: begin
                sap_re = 1'b0;
            end
        endcase
    end

    // Back-index port.
    always_comb begin
        pos_re   = 1'b0;
        pos_we   = 1'b0;
        pos_addr = r_init_idx;
        pos_wd   = r_init_idx;
        case (ctl.pos_op)
            POS_NONE: begin
                pos_re = 1'b0;
            end
            POS_RD_SLOT: begin
                pos_re   = effects;
                pos_addr = slot_addr;
            end
            POS_WR_LASTSLOT: begin
                pos_we   = effects;
                pos_addr = r_sap_q;
                pos_wd   = r_hole;
            end
            POS_WR_SLOT: begin
                pos_we   = effects;
                pos_addr = slot_addr;
                pos_wd   = cnt_m1[PW-1:0];
            end
            POS_WR_INIT: begin
                pos_we   = effects;
                pos_addr = r_init_idx;
                pos_wd   = r_init_idx;
            end
            default: begin
                pos_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sap_we) begin
            sap_mem[sap_addr] <= sap_wd;
        end
        if (sap_re) begin
            r_sap_q <= sap_mem[sap_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_addr] <= pos_wd;
        end
        if (pos_re) begin
            r_pos_q <= pos_mem[pos_addr];
        end
    end

    // Count update and step sequencing.
    always_comb begin
        n_cnt = r_cnt;
        if (effects) begin
            case (ctl.cnt_op)
                CNT_HOLD: n_cnt = r_cnt;
                CNT_INC:  n_cnt = r_cnt + CW'(1);
                CNT_DEC:  n_cnt = cnt_m1;
                CNT_ZERO: n_cnt = '0;
                default:  n_cnt = r_cnt;
            endcase
        end
    end

    always_comb begin
        n_step = r_step;
        if (r_step == S_IDLE) begin
            if (in_accept) begin
                n_step = entry_step(i_mode);
            end
        end else if (advance) begin
            n_step = cond_true ? S_IDLE : ctl.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_INIT;
            r_init_idx  <= '0;
            r_cnt       <= '0;
            r_cap       <= 7'd64;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
            if (effects && ctl.init_inc) begin
                r_init_idx <= r_init_idx + PW'(1);
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (run && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_mode;
            r_slot <= i_slot;
        end
        if (effects && ctl.ld_hole) begin
            r_hole <= r_pos_q;
        end
        if (run && emit) begin
            r_status   <= (cond_true && ctl.cond_fail) ? ctl.fail_status : ST_OK;
            r_given    <= ctl.ld_given ? r_sap_q : '0;
            r_position <= ctl.ld_given ? r_cnt[PW-1:0] : '0;
            r_occupied <= n_cnt;
        end
    end

    assign given_ext    = EW'(r_given);
    assign position_ext = EW'(r_position);
    assign occupied_ext = EW'(r_occupied);

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_given_slot = given_ext[5:0];
    assign o_position   = position_ext[5:0];
    assign o_occupied   = occupied_ext[6:0];

    // An accepted beat always starts a microprogram.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_step != S_IDLE))
        else $error("accepted beat did not start a program");

    // The occupied count never goes beyond the built size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_cnt) <= slots_ext)
        else $error("occupied count beyond pool size");

    // A result step that meets a stalled output register holds its place.
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_out_valid && i_out_stall) |=> $stable(r_step) && $stable(r_cnt))
        else $error("sequencer moved while its result was blocked");

    // The clearing pass runs once after reset and is never re-entered.
    a_init_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_INIT) |=> (r_step != S_INIT))
        else $error("clearing pass re-entered");

endmodule

// ===== tb/sv/dense_slot_pool_allocator_core_tb.sv =====
module dense_slot_pool_allocator_core_tb;
    import dspa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS = 64;
    // Run limit in clock cycles.
    localparam int RUN_LIMIT  = 200000;
    // Random phases and the number of beats in each.
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 75;

    // One result beat, in the order of the output ports.
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] given;
        logic [5:0] pos;
        logic [6:0] occ;
    } t_pool_res;

    // One row of the directed plan: either a capacity write or an input beat.
    // A beat row may carry a hand-written result. Without one, the row is
    // checked against the pool model below.
    typedef struct packed {
        logic       is_cfg;
        logic [6:0] cap;
        logic [1:0] mode;
        logic [5:0] slot;
        logic       typed;
        t_pool_res  want;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_mode;
    logic [5:0] i_slot;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_status;
    logic [5:0] o_given_slot;
    logic [5:0] o_position;
    logic [6:0] o_occupied;

    dense_slot_pool_allocator_core #(
        .SLOTS(POOL_SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_given_slot (o_given_slot),
        .o_position   (o_position),
        .o_occupied   (o_occupied)
    );

    // Model of the pool: the dense list, the back-index of every slot, the
    // occupied count and the capacity register as last written.
    logic [5:0] list_slot [POOL_SLOTS];
    logic [5:0] slot_pos  [POOL_SLOTS];
    logic [6:0] n_used;
    logic [6:0] cap_reg;

    // Results still owed by the block, oldest first.
    t_pool_res  results_due [$];
    t_pool_res  got_want;
    int         errors;
    int         clk_count;
    // While set, neither side inserts gaps or stalls.
    bit         steady;
    t_row       plan [$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A slot is occupied when its back-index lies below the count and the
    // list entry there points back at it.
    function automatic logic slot_held(input logic [5:0] s);
        logic [5:0] p;
        p = slot_pos[s];
        return ({1'b0, p} < n_used) && (list_slot[p] == s);
    endfunction

    // Applies one beat to the pool model and returns the result it causes.
    function automatic t_pool_res pool_apply(input logic [1:0] m, input logic [5:0] s);
        t_pool_res  r;
        logic [6:0] limit;
        logic [5:0] hole;
        logic [5:0] tail_slot;
        r = '0;
        r.status = ST_OK;
        // Capacity above the built size behaves as the built size.
        limit = (cap_reg > 7'(POOL_SLOTS)) ? 7'(POOL_SLOTS) : cap_reg;
        case (m)
            MODE_RESERVE: begin
                if (n_used >= limit) begin
                    r.status = ST_FULL;
                end else begin
                    r.pos   = n_used[5:0];
                    r.given = list_slot[n_used[5:0]];
                    n_used  = n_used + 7'd1;
                end
            end
            MODE_RELEASE: begin
                if (!slot_held(s)) begin
                    r.status = ST_NOTOCC;
                end else begin
                    // Swap-remove: the last occupied slot fills the hole and
                    // the released slot moves to the old tail position.
                    hole      = slot_pos[s];
                    n_used    = n_used - 7'd1;
                    tail_slot = list_slot[n_used[5:0]];
                    list_slot[hole]        = tail_slot;
                    list_slot[n_used[5:0]] = s;
                    slot_pos[tail_slot]    = hole;
                    slot_pos[s]            = n_used[5:0];
                end
            end
            MODE_TEST: begin
                if (!slot_held(s)) begin
                    r.status = ST_NOTOCC;
                end
            end
            default: begin
                // Clear keeps the list order and only drops the count.
                n_used = '0;
            end
        endcase
        r.occ = n_used;
        return r;
    endfunction

    function automatic t_row op_row(input logic [1:0] m, input logic [5:0] s);
        t_row r;
        r = '0;
        r.mode = m;
        r.slot = s;
        return r;
    endfunction

    function automatic t_row known_row(input logic [1:0] m, input logic [5:0] s,
                                       input logic [1:0] st, input logic [5:0] g,
                                       input logic [5:0] p, input logic [6:0] o);
        t_row r;
        r = op_row(m, s);
        r.typed       = 1'b1;
        r.want.status = st;
        r.want.given  = g;
        r.want.pos    = p;
        r.want.occ    = o;
        return r;
    endfunction

    function automatic t_row cap_row(input logic [6:0] v);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cap    = v;
        return r;
    endfunction

    // Sends one input beat. Called and returning at a falling edge. The beat
    // is taken at the first rising edge with valid high and stall low; the
    // model is stepped right there so that results stay in acceptance order.
    task automatic issue(input logic [1:0] m, input logic [5:0] s,
                         input logic typed, input t_pool_res want);
        t_pool_res pred;
        while (!steady && $urandom_range(0, 99) < 23) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode     = m;
        i_slot     = s;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pred = pool_apply(m, s);
        results_due.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Writes the capacity register once the block has handed back every
    // result, so that no beat is in flight when the limit changes.
    task automatic set_capacity(input logic [6:0] v);
        i_in_valid = 1'b0;
        while (results_due.size() != 0) begin
            @(negedge i_clk);
        end
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        cap_reg    = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = 7'($urandom_range(0, 127));
    endtask

    task automatic check_field(input string name, input logic [6:0] exp_v,
                               input logic [6:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Output side: stall in roughly a quarter of the cycles, except during the
    // steady stretch. The stall only changes at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall = !steady && ($urandom_range(0, 99) < 23);
    end

    // Every result beat is compared field by field with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t ns: result beat with none expected, actual status %0d",
                         $time, o_status);
                errors++;
            end else begin
                got_want = results_due.pop_front();
                check_field("status", 7'(got_want.status), 7'(o_status));
                check_field("given_slot", 7'(got_want.given), 7'(o_given_slot));
                check_field("position", 7'(got_want.pos), 7'(o_position));
                check_field("occupied", got_want.occ, o_occupied);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        clk_count = 0;
        while (clk_count < RUN_LIMIT) begin
            @(posedge i_clk);
            clk_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [1:0] m;
        logic [5:0] s;
        logic [6:0] cap_v;
        int         rsv_pct;
        int         clr_pct;
        int         roll;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_RESERVE;
        i_slot      = '0;
        i_out_stall = 1'b0;
        errors      = 0;
        steady      = 1'b0;

        for (int k = 0; k < POOL_SLOTS; k++) begin
            list_slot[k] = 6'(k);
            slot_pos[k]  = 6'(k);
        end
        n_used  = '0;
        cap_reg = 7'(POOL_SLOTS);

        // Directed plan. Starts from reset: identity list, empty pool, full
        // capacity. After the first successful release the list is no longer the
        // identity, so most later rows lean on the model.
        plan.push_back(known_row(MODE_TEST,    6'd0,  ST_NOTOCC, 6'd0, 6'd0, 7'd0));
        plan.push_back(known_row(MODE_RELEASE, 6'd63, ST_NOTOCC, 6'd0, 6'd0, 7'd0));
        plan.push_back(known_row(MODE_RESERVE, 6'd63, ST_OK,     6'd0, 6'd0, 7'd1));
        plan.push_back(known_row(MODE_RESERVE, 6'd0,  ST_OK,     6'd1, 6'd1, 7'd2));
        plan.push_back(known_row(MODE_RESERVE, 6'd21, ST_OK,     6'd2, 6'd2, 7'd3));
        plan.push_back(known_row(MODE_TEST,    6'd1,  ST_OK,     6'd0, 6'd0, 7'd3));
        // Slot 3 points at position 3, which equals the count: not occupied.
        plan.push_back(known_row(MODE_TEST,    6'd3,  ST_NOTOCC, 6'd0, 6'd0, 7'd3));
        // Releasing slot 0 pulls slot 2 from the tail into position 0.
        plan.push_back(known_row(MODE_RELEASE, 6'd0,  ST_OK,     6'd0, 6'd0, 7'd2));
        // A second release of the same slot finds its back-index at the count.
        plan.push_back(known_row(MODE_RELEASE, 6'd0,  ST_NOTOCC, 6'd0, 6'd0, 7'd2));
        plan.push_back(op_row(MODE_TEST, 6'd2));
        // Capacity lowered below the count: reserves are refused until
        // releases bring the count under the new limit.
        plan.push_back(cap_row(7'd1));
        plan.push_back(known_row(MODE_RESERVE, 6'd0,  ST_FULL,   6'd0, 6'd0, 7'd2));
        plan.push_back(op_row(MODE_RELEASE, 6'd2));
        plan.push_back(op_row(MODE_RESERVE, 6'd42));
        plan.push_back(op_row(MODE_RELEASE, 6'd1));
        plan.push_back(op_row(MODE_RESERVE, 6'd0));
        // Capacity of zero: the pool is always full.
        plan.push_back(cap_row(7'd0));
        plan.push_back(op_row(MODE_RESERVE, 6'd63));
        plan.push_back(known_row(MODE_CLEAR,   6'd63, ST_OK,     6'd0, 6'd0, 7'd0));
        plan.push_back(known_row(MODE_RESERVE, 6'd0,  ST_FULL,   6'd0, 6'd0, 7'd0));
        // Capacity beyond the built size saturates.
        plan.push_back(cap_row(7'd127));
        plan.push_back(op_row(MODE_RESERVE, 6'd0));
        plan.push_back(op_row(MODE_RESERVE, 6'd0));
        plan.push_back(op_row(MODE_TEST, 6'd63));
        plan.push_back(known_row(MODE_CLEAR,   6'd0,  ST_OK,     6'd0, 6'd0, 7'd0));
        plan.push_back(cap_row(7'd64));
        plan.push_back(known_row(MODE_RELEASE, 6'd63, ST_NOTOCC, 6'd0, 6'd0, 7'd0));

        // Synchronous reset, then the block runs its clearing pass. Input beats
        // are held off by the stall until that pass is over.
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                set_capacity(plan[k].cap);
            end else begin
                issue(plan[k].mode, plan[k].slot, plan[k].typed, plan[k].want);
            end
        end

        // Random phases, each under its own capacity and operation mix. The
        // first one leans hard on reserves with no clears, so the pool reaches
        // its full size. Releases and tests mostly name a slot that is
        // occupied, so that swap-remove is exercised at every depth.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    cap_v = 7'd64; rsv_pct = 100; clr_pct = 0;
                end
                1: begin
                    cap_v = 7'd127; rsv_pct = 40; clr_pct = 2;
                end
                2: begin
                    cap_v = 7'($urandom_range(2, 63)); rsv_pct = 50; clr_pct = 2;
                end
                3: begin
                    cap_v = 7'd1; rsv_pct = 50; clr_pct = 2;
                end
                4: begin
                    cap_v = 7'd0; rsv_pct = 40; clr_pct = 2;
                end
                5: begin
                    cap_v = 7'($urandom_range(1, 64)); rsv_pct = 55; clr_pct = 3;
                end
                6: begin
                    cap_v = 7'd64; rsv_pct = 60; clr_pct = 1;
                end
                default: begin
                    cap_v = 7'($urandom_range(0, 127)); rsv_pct = 50; clr_pct = 3;
                end
            endcase
            // One phase runs back to back on both sides.
            steady = (ph == 5);
            set_capacity(cap_v);
            repeat (PHASE_LEN) begin
                roll = $urandom_range(0, 99);
                if (roll < clr_pct) begin
                    m = MODE_CLEAR;
                end else if (roll < clr_pct + rsv_pct) begin
                    m = MODE_RESERVE;
                end else if (roll < clr_pct + rsv_pct + (100 - clr_pct - rsv_pct) * 2 / 3) begin
                    m = MODE_RELEASE;
                end else begin
                    m = MODE_TEST;
                end
                s = 6'($urandom_range(0, 63));
                if ((m == MODE_RELEASE || m == MODE_TEST) && n_used != 0
                        && $urandom_range(0, 9) < 8) begin
                    s = list_slot[$urandom_range(0, int'(n_used) - 1)];
                end
                issue(m, s, 1'b0, '0);
            end
        end
        steady = 1'b0;

        i_in_valid = 1'b0;
        while (results_due.size() != 0) begin
            @(negedge i_clk);
        end
        // Keep clocking afterwards to catch any stray result beat.
        repeat (16) @(negedge i_clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
